### hdl/ntc_r2t_pkg.sv
// ----------------------------------------------------------------------------
// NTC resistance to temperature: shared package
// Word layouts, register indexes, request codes and reset values.
// ----------------------------------------------------------------------------
package ntc_r2t_pkg;

    localparam int OHM_BITS        = 24;
    localparam int WARM_POINTS_DEF = 32;
    localparam int COLD_POINTS_DEF = 16;
    localparam int STEP_W          = 6;
    localparam int TEMP_W          = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WARM_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLD_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOT_CLAMP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLD_CLAMP = 2'd3;

    localparam logic [1:0] REQ_WRITE_WARM = 2'd0;
    localparam logic [1:0] REQ_WRITE_COLD = 2'd1;
    localparam logic [1:0] REQ_CONVERT    = 2'd2;

    localparam logic [STEP_W-1:0]        WARM_STEP_RST  = 6'd5;
    localparam logic [STEP_W-1:0]        COLD_STEP_RST  = 6'd5;
    localparam logic signed [TEMP_W-1:0] HOT_CLAMP_RST  = 16'sd9600;
    localparam logic signed [TEMP_W-1:0] COLD_CLAMP_RST = -16'sd2560;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [5:0]          entry_index;
        logic [OHM_BITS-1:0] entry_ohms;
        logic [OHM_BITS-1:0] resistance_ohm;
    } t_req;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     clamped;
        logic                     cold_side;
    } t_res;

endpackage

### hdl/ntc_r2t_ram.sv
// ----------------------------------------------------------------------------
// NTC resistance to temperature: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ntc_r2t_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 33,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/ntc_r2t_div.sv
// ----------------------------------------------------------------------------
// NTC resistance to temperature: serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntc_r2t_div #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 24,
    localparam int CW   = $clog2(NUM_W + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    logic             r_run;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(NUM_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_run) begin
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### hdl/ntc_resistance_to_temperature.sv
// ----------------------------------------------------------------------------
// NTC resistance to temperature converter
// Table walk over two loaded resistance tables and linear interpolation.
// ----------------------------------------------------------------------------
// A table write word is taken without raising busy. A convert word raises busy
// until its result appears: a head step checks warm entry zero and chooses the
// table, the walk reads the table entry by entry, then a multiply step and the
// bit-serial divider follow, and the divider sets most of the latency. A clamped
// result ends at the walk and skips the multiply and the divider. The result word
// shows on o_res for exactly one cycle with o_valid and must be taken then.
// ----------------------------------------------------------------------------
module ntc_resistance_to_temperature #(
    parameter int WARM_POINTS = ntc_r2t_pkg::WARM_POINTS_DEF,
    parameter int COLD_POINTS = ntc_r2t_pkg::COLD_POINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ntc_r2t_pkg::t_req                   i_req,
    output logic                                o_valid,
    output ntc_r2t_pkg::t_res                   o_res,
    input  logic                                i_cfg_we,
    input  logic [ntc_r2t_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ntc_r2t_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int OB   = ntc_r2t_pkg::OHM_BITS;
    localparam int SW6  = ntc_r2t_pkg::STEP_W;
    localparam int TW   = ntc_r2t_pkg::TEMP_W;
    localparam int MAXP = (WARM_POINTS > COLD_POINTS) ? WARM_POINTS : COLD_POINTS;
    localparam int IW   = $clog2(MAXP + 1);
    localparam int XW   = IW + 2;
    localparam int WAW  = $clog2(WARM_POINTS + 1);
    localparam int CAW  = $clog2(COLD_POINTS + 1);
    localparam int NW   = OB + 13;
    localparam int BW   = IW + 12;
    localparam int SW   = NW + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HEAD = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;

    localparam logic signed [SW-1:0] T_MAX = SW'(32767);
    localparam logic signed [SW-1:0] T_MIN = SW'(-32768);

    logic [2:0]            r_state;
    logic [SW6-1:0]        r_warm_step;
    logic [SW6-1:0]        r_cold_step;
    logic signed [TW-1:0]  r_hot_clamp;
    logic signed [TW-1:0]  r_cold_clamp;
    logic [IW-1:0]         r_i;
    logic                  r_cold;
    logic                  r_div_go;
    logic                  r_valid;
    logic [OB-1:0]         r_r;
    logic [OB-1:0]         r_a;
    logic [OB-1:0]         r_b;
    logic [NW-1:0]         r_num;
    logic [OB-1:0]         r_den;
    logic                  r_neg;
    logic                  r_den_zero;
    logic [BW-1:0]         r_base;
    ntc_r2t_pkg::t_res     r_res;

    logic                  w_accept;
    logic                  w_warm_we;
    logic                  w_cold_we;
    logic [XW-1:0]         w_rd_idx;
    logic [WAW-1:0]        w_warm_raddr;
    logic [CAW-1:0]        w_cold_raddr;
    logic [OB-1:0]         w_warm_rd;
    logic [OB-1:0]         w_cold_rd;
    logic [OB-1:0]         w_b;
    logic                  w_at_end;
    logic                  w_go_on;
    logic [SW6-1:0]        w_step;
    logic [OB:0]           w_diff;
    logic [OB:0]           w_den;
    logic [OB:0]           w_diff_abs;
    logic [OB:0]           w_den_abs;
    logic [OB+5:0]         w_prod;
    logic [IW+5:0]         w_base_p;
    logic [NW-1:0]         w_num;
    logic                  w_div_done;
    logic [NW-1:0]         w_quot;
    logic signed [SW-1:0]  w_base_s;
    logic signed [SW-1:0]  w_frac_s;
    logic signed [SW-1:0]  w_t;
    logic signed [TW-1:0]  w_t_sat;

    assign w_accept  = start && !busy;
    assign w_warm_we = w_accept && (i_req.req_type == ntc_r2t_pkg::REQ_WRITE_WARM)
                       && ({3'b000, i_req.entry_index} < 9'(WARM_POINTS + 1));
    assign w_cold_we = w_accept && (i_req.req_type == ntc_r2t_pkg::REQ_WRITE_COLD)
                       && ({3'b000, i_req.entry_index} < 9'(COLD_POINTS + 1));

    always_comb begin
        case (r_state)
            S_IDLE:  w_rd_idx = '0;
            S_HEAD:  w_rd_idx = XW'(1);
            S_WALK:  w_rd_idx = {2'b00, r_i} + XW'(2);
            default: w_rd_idx = '0;
        endcase
    end

    assign w_warm_raddr = (w_rd_idx > XW'(WARM_POINTS)) ? WAW'(WARM_POINTS) : WAW'(w_rd_idx);
    assign w_cold_raddr = (w_rd_idx > XW'(COLD_POINTS)) ? CAW'(COLD_POINTS) : CAW'(w_rd_idx);

    ntc_r2t_ram #(
        .WIDTH (OB),
        .DEPTH (WARM_POINTS + 1)
    ) u_warm_ram (
        .i_clk   (i_clk),
        .i_we    (w_warm_we),
        .i_waddr (WAW'(i_req.entry_index)),
        .i_wdata (i_req.entry_ohms),
        .i_raddr (w_warm_raddr),
        .o_rdata (w_warm_rd)
    );

    ntc_r2t_ram #(
        .WIDTH (OB),
        .DEPTH (COLD_POINTS + 1)
    ) u_cold_ram (
        .i_clk   (i_clk),
        .i_we    (w_cold_we),
        .i_waddr (CAW'(i_req.entry_index)),
        .i_wdata (i_req.entry_ohms),
        .i_raddr (w_cold_raddr),
        .o_rdata (w_cold_rd)
    );

    assign w_b      = r_cold ? w_cold_rd : w_warm_rd;
    assign w_at_end = r_cold ? (r_i == IW'(COLD_POINTS)) : (r_i == IW'(WARM_POINTS));
    assign w_go_on  = r_cold ? (r_r > w_b) : (r_r < w_b);

    assign w_step     = r_cold ? r_cold_step : r_warm_step;
    assign w_diff     = {1'b0, r_r} - {1'b0, r_a};
    assign w_den      = {1'b0, r_b} - {1'b0, r_a};
    assign w_diff_abs = w_diff[OB] ? (~w_diff + 1'b1) : w_diff;
    assign w_den_abs  = w_den[OB] ? (~w_den + 1'b1) : w_den;
    assign w_prod     = {{OB{1'b0}}, w_step} * {6'b000000, w_diff_abs[OB-1:0]};
    assign w_base_p   = {{6{1'b0}}, r_i} * {{IW{1'b0}}, w_step};
    assign w_num      = {1'b0, w_prod, 6'b000000} + {{14{1'b0}}, w_den_abs[OB-1:1]};

    ntc_r2t_div #(
        .NUM_W (NW),
        .DEN_W (OB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_base_s = $signed({{(SW - BW){1'b0}}, r_base});
    assign w_frac_s = r_den_zero ? '0 : $signed({2'b00, w_quot});
    assign w_t      = (r_cold ? -w_base_s : w_base_s)
                      + ((r_neg ^ r_cold) ? -w_frac_s : w_frac_s);
    assign w_t_sat  = (w_t > T_MAX) ? TW'(T_MAX) :
                      (w_t < T_MIN) ? TW'(T_MIN) : w_t[TW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_warm_step  <= ntc_r2t_pkg::WARM_STEP_RST;
            r_cold_step  <= ntc_r2t_pkg::COLD_STEP_RST;
            r_hot_clamp  <= ntc_r2t_pkg::HOT_CLAMP_RST;
            r_cold_clamp <= ntc_r2t_pkg::COLD_CLAMP_RST;
            r_i          <= '0;
            r_cold       <= 1'b0;
            r_div_go     <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            r_valid  <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ntc_r2t_pkg::REG_WARM_STEP:  r_warm_step  <= i_cfg_data[SW6-1:0];
                    ntc_r2t_pkg::REG_COLD_STEP:  r_cold_step  <= i_cfg_data[SW6-1:0];
                    ntc_r2t_pkg::REG_HOT_CLAMP:  r_hot_clamp  <= $signed(i_cfg_data);
                    ntc_r2t_pkg::REG_COLD_CLAMP: r_cold_clamp <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_req.req_type == ntc_r2t_pkg::REQ_CONVERT)) begin
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_cold  <= !(r_r <= w_warm_rd);
                    r_i     <= '0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (w_at_end) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (w_go_on) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_div_go <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_r <= i_req.resistance_ohm;
                end
            end
            S_HEAD: begin
                r_a <= (r_r <= w_warm_rd) ? w_warm_rd : w_cold_rd;
            end
            S_WALK: begin
                if (w_at_end) begin
                    r_res.temperature <= r_cold ? r_cold_clamp : r_hot_clamp;
                    r_res.clamped     <= 1'b1;
                    r_res.cold_side   <= r_cold;
                end else if (w_go_on) begin
                    r_a <= w_b;
                end else begin
                    r_b <= w_b;
                end
            end
            S_MUL: begin
                r_num      <= w_num;
                r_den      <= w_den_abs[OB-1:0];
                r_neg      <= w_diff[OB] ^ w_den[OB];
                r_den_zero <= (w_den == '0);
                r_base     <= {w_base_p, 6'b000000};
            end
            S_DIV: begin
                if (w_div_done) begin
                    r_res.temperature <= w_t_sat;
                    r_res.clamped     <= 1'b0;
                    r_res.cold_side   <= r_cold;
                end
            end
            default: ;
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### verif/ntc_resistance_to_temperature_test.sv
// ----------------------------------------------------------------------------
// NTC resistance to temperature converter: testbench
// Loads both resistance tables, then converts resistances at the table edges,
// inside segments and past the clamps under several register settings, then
// runs random table rewrites and conversions. A predictor built in this file
// tracks the tables and registers and checks every result word in order.
// ----------------------------------------------------------------------------
module ntc_resistance_to_temperature_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WARM_POINTS       = ntc_r2t_pkg::WARM_POINTS_DEF;
    localparam int          COLD_POINTS       = ntc_r2t_pkg::COLD_POINTS_DEF;
    localparam int unsigned OHM_MAX           = (1 << ntc_r2t_pkg::OHM_BITS) - 1;
    localparam int          STALL_LIMIT       = 2000;
    localparam int          SETTLE_CYCLES     = 100;
    localparam int          RANDOM_PHASES     = 4;
    localparam int          PHASE_MIXED_WORDS = 30;
    localparam int          MAX_REPORTS       = 50;
    localparam logic [1:0]  REQ_UNUSED        = 2'd3;

    logic                                   i_clk;
    logic                                   i_rst_n    = 1'b0;
    logic                                   start      = 1'b0;
    logic                                   busy;
    ntc_r2t_pkg::t_req                      i_req      = '0;
    logic                                   o_valid;
    ntc_r2t_pkg::t_res                      o_res;
    logic                                   i_cfg_we   = 1'b0;
    logic [ntc_r2t_pkg::CFG_IDX_W-1:0]      i_cfg_idx  = '0;
    logic [ntc_r2t_pkg::CFG_DATA_W-1:0]     i_cfg_data = '0;

    logic [ntc_r2t_pkg::OHM_BITS-1:0]       warm_ohms [0:WARM_POINTS];
    logic [ntc_r2t_pkg::OHM_BITS-1:0]       cold_ohms [0:COLD_POINTS];
    logic [ntc_r2t_pkg::STEP_W-1:0]         warm_step  = ntc_r2t_pkg::WARM_STEP_RST;
    logic [ntc_r2t_pkg::STEP_W-1:0]         cold_step  = ntc_r2t_pkg::COLD_STEP_RST;
    logic signed [ntc_r2t_pkg::TEMP_W-1:0]  hot_clamp  = ntc_r2t_pkg::HOT_CLAMP_RST;
    logic signed [ntc_r2t_pkg::TEMP_W-1:0]  cold_clamp = ntc_r2t_pkg::COLD_CLAMP_RST;

    ntc_r2t_pkg::t_res temp_readings_due[$];
    int   mismatch_count = 0;
    int   idle_cycles    = 0;
    bit   sender_pauses  = 1'b1;

    ntc_resistance_to_temperature u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint rounded_quotient(longint num, longint den);
        longint n;
        longint d;
        longint q;
        bit     neg;
        neg = (num < 0) != (den < 0);
        n   = (num < 0) ? -num : num;
        d   = (den < 0) ? -den : den;
        q   = (n + d / 2) / d;
        return neg ? -q : q;
    endfunction

    function automatic longint segment_fraction(longint r, longint a, longint b, longint step);
        if (b == a) begin
            return 0;
        end
        return rounded_quotient(step * 64 * (r - a), b - a);
    endfunction

    function automatic longint saturate_temp(longint v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function automatic ntc_r2t_pkg::t_res convert_to_temp(
            logic [ntc_r2t_pkg::OHM_BITS-1:0] ohms);
        ntc_r2t_pkg::t_res res;
        int                seg;
        longint            t;
        res = '0;
        seg = 0;
        if (ohms <= warm_ohms[0]) begin
            while (seg < WARM_POINTS && ohms < warm_ohms[seg + 1]) seg++;
            if (seg < WARM_POINTS) begin
                t = saturate_temp(longint'(seg) * longint'(warm_step) * 64
                    + segment_fraction(longint'(ohms), longint'(warm_ohms[seg]),
                                       longint'(warm_ohms[seg + 1]), longint'(warm_step)));
            end else begin
                t = longint'(hot_clamp);
                res.clamped = 1'b1;
            end
        end else begin
            res.cold_side = 1'b1;
            while (seg < COLD_POINTS && ohms > cold_ohms[seg + 1]) seg++;
            if (seg < COLD_POINTS) begin
                t = saturate_temp(-(longint'(seg) * longint'(cold_step) * 64)
                    - segment_fraction(longint'(ohms), longint'(cold_ohms[seg]),
                                       longint'(cold_ohms[seg + 1]), longint'(cold_step)));
            end else begin
                t = longint'(cold_clamp);
                res.clamped = 1'b1;
            end
        end
        res.temperature = t[ntc_r2t_pkg::TEMP_W-1:0];
        return res;
    endfunction

    function automatic void apply_word(ntc_r2t_pkg::t_req w);
        case (w.req_type)
            ntc_r2t_pkg::REQ_WRITE_WARM: begin
                if (w.entry_index <= WARM_POINTS) warm_ohms[w.entry_index] = w.entry_ohms;
            end
            ntc_r2t_pkg::REQ_WRITE_COLD: begin
                if (w.entry_index <= COLD_POINTS) cold_ohms[w.entry_index] = w.entry_ohms;
            end
            ntc_r2t_pkg::REQ_CONVERT: begin
                temp_readings_due.push_back(convert_to_temp(w.resistance_ohm));
            end
            default: ;
        endcase
    endfunction

    function automatic int unsigned clamp_ohms(longint v);
        if (v < 0) begin
            return 0;
        end
        if (v > longint'(OHM_MAX)) begin
            return OHM_MAX;
        end
        return int'(v);
    endfunction

    function automatic int unsigned pick_resistance();
        int     k;
        int     offset;
        longint v;
        k      = $urandom_range(0, WARM_POINTS - 1);
        offset = int'($urandom_range(0, 4)) - 2;
        case ($urandom_range(0, 7))
            0, 1: v = longint'(warm_ohms[$urandom_range(0, WARM_POINTS)]) + offset;
            2, 3: v = longint'(cold_ohms[$urandom_range(0, COLD_POINTS)]) + offset;
            4, 5: v = longint'($urandom_range(warm_ohms[k], warm_ohms[k + 1]));
            6: begin
                k = $urandom_range(0, COLD_POINTS - 1);
                v = longint'($urandom_range(cold_ohms[k], cold_ohms[k + 1]));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 64'sd0;
                    1: v = longint'(OHM_MAX);
                    2: v = longint'(warm_ohms[0]) + longint'($urandom_range(0, 1));
                    default: v = longint'(cold_ohms[COLD_POINTS])
                                 + longint'($urandom_range(0, 1));
                endcase
            end
        endcase
        return clamp_ohms(v);
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch in %s at %0t: got %0d, expected %0d", field, $time, got, want);
        end
    endtask

    // The word stays on i_req through the edge that takes it and until busy is seen
    // low; the caller then either sends the next word or lowers start in that same step.
    task automatic send_word(ntc_r2t_pkg::t_req w);
        if (sender_pauses && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= w;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        apply_word(w);
    endtask

    task automatic send_entry(logic [1:0] kind, int idx, int unsigned ohms);
        ntc_r2t_pkg::t_req w;
        w.req_type       = kind;
        w.entry_index    = 6'(idx);
        w.entry_ohms     = ohms[ntc_r2t_pkg::OHM_BITS-1:0];
        w.resistance_ohm = ntc_r2t_pkg::OHM_BITS'($urandom);
        send_word(w);
    endtask

    task automatic send_reading(int unsigned ohms);
        ntc_r2t_pkg::t_req w;
        w.req_type       = ntc_r2t_pkg::REQ_CONVERT;
        w.entry_index    = 6'($urandom);
        w.entry_ohms     = ntc_r2t_pkg::OHM_BITS'($urandom);
        w.resistance_ohm = ohms[ntc_r2t_pkg::OHM_BITS-1:0];
        send_word(w);
    endtask

    task automatic send_unused_word();
        ntc_r2t_pkg::t_req w;
        w.req_type       = REQ_UNUSED;
        w.entry_index    = 6'($urandom);
        w.entry_ohms     = ntc_r2t_pkg::OHM_BITS'($urandom);
        w.resistance_ohm = ntc_r2t_pkg::OHM_BITS'($urandom);
        send_word(w);
    endtask

    task automatic wait_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (temp_readings_due.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_registers(logic [ntc_r2t_pkg::STEP_W-1:0] ws,
                                     logic [ntc_r2t_pkg::STEP_W-1:0] cs,
                                     logic [ntc_r2t_pkg::TEMP_W-1:0] hc,
                                     logic [ntc_r2t_pkg::TEMP_W-1:0] cc);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ntc_r2t_pkg::REG_WARM_STEP;
        i_cfg_data <= ntc_r2t_pkg::CFG_DATA_W'(ws);
        @(posedge i_clk);
        i_cfg_idx  <= ntc_r2t_pkg::REG_COLD_STEP;
        i_cfg_data <= ntc_r2t_pkg::CFG_DATA_W'(cs);
        @(posedge i_clk);
        i_cfg_idx  <= ntc_r2t_pkg::REG_HOT_CLAMP;
        i_cfg_data <= hc;
        @(posedge i_clk);
        i_cfg_idx  <= ntc_r2t_pkg::REG_COLD_CLAMP;
        i_cfg_data <= cc;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        warm_step  = ws;
        cold_step  = cs;
        hot_clamp  = hc;
        cold_clamp = cc;
    endtask

    task automatic reload_tables(bit noisy);
        int unsigned level;
        level = $urandom_range(4096, OHM_MAX);
        for (int i = 0; i <= WARM_POINTS; i++) begin
            send_entry(ntc_r2t_pkg::REQ_WRITE_WARM, i, noisy ? $urandom : level);
            level -= $urandom_range(0, level / 20);
        end
        level = $urandom_range(warm_ohms[0], OHM_MAX);
        for (int i = 0; i <= COLD_POINTS; i++) begin
            send_entry(ntc_r2t_pkg::REQ_WRITE_COLD, i, noisy ? $urandom : level);
            level += $urandom_range(0, (OHM_MAX - level) / 10);
        end
    endtask

    task automatic send_mixed_word();
        int unsigned pick;
        int          idx;
        pick = $urandom_range(0, 19);
        if (pick <= 13) begin
            send_reading(pick_resistance());
        end else if (pick == 14) begin
            idx = $urandom_range(0, WARM_POINTS);
            send_entry(ntc_r2t_pkg::REQ_WRITE_WARM, idx,
                       clamp_ohms(longint'(warm_ohms[idx]) + int'($urandom_range(0, 64)) - 32));
        end else if (pick == 15) begin
            idx = $urandom_range(0, COLD_POINTS);
            send_entry(ntc_r2t_pkg::REQ_WRITE_COLD, idx,
                       clamp_ohms(longint'(cold_ohms[idx]) + int'($urandom_range(0, 64)) - 32));
        end else if (pick == 16) begin
            if ($urandom_range(0, 1))
                send_entry(ntc_r2t_pkg::REQ_WRITE_WARM, $urandom_range(0, WARM_POINTS), $urandom);
            else
                send_entry(ntc_r2t_pkg::REQ_WRITE_COLD, $urandom_range(0, COLD_POINTS), $urandom);
        end else if (pick == 17) begin
            if ($urandom_range(0, 1))
                send_entry(ntc_r2t_pkg::REQ_WRITE_WARM, $urandom_range(WARM_POINTS + 1, 63),
                           $urandom);
            else
                send_entry(ntc_r2t_pkg::REQ_WRITE_COLD, $urandom_range(COLD_POINTS + 1, 63),
                           $urandom);
        end else if (pick == 18) begin
            send_unused_word();
        end else begin
            send_reading($urandom);
        end
    endtask

    // Warm entries fall by 3000 ohms per step and cold entries rise by 50000, except that
    // one entry in each table is moved to make a 640 ohm segment that yields exact halves.
    task automatic test_table_load();
        for (int i = 0; i <= WARM_POINTS; i++) begin
            send_entry(ntc_r2t_pkg::REQ_WRITE_WARM, i, (i == 3) ? 93360 : 100000 - 3000 * i);
        end
        for (int i = 0; i <= COLD_POINTS; i++) begin
            send_entry(ntc_r2t_pkg::REQ_WRITE_COLD, i, (i == 2) ? 150640 : 100000 + 50000 * i);
        end
    endtask

    task automatic test_default_conversions();
        int unsigned probes[] = '{100000, 0, 4000, 3999, 93999, 50000, 100001,
                                  150001, 900000, 900001, OHM_MAX};
        foreach (probes[i]) send_reading(probes[i]);
    endtask

    task automatic test_segment_corners();
        send_entry(ntc_r2t_pkg::REQ_WRITE_WARM, 1, 100000);
        send_reading(100000);
        send_entry(ntc_r2t_pkg::REQ_WRITE_WARM, 1, 97000);
        send_entry(ntc_r2t_pkg::REQ_WRITE_COLD, 0, 150000);
        send_reading(120000);
        send_entry(ntc_r2t_pkg::REQ_WRITE_COLD, 0, 100000);
    endtask

    task automatic test_ignored_words();
        send_entry(ntc_r2t_pkg::REQ_WRITE_WARM, WARM_POINTS + 1, $urandom);
        send_entry(ntc_r2t_pkg::REQ_WRITE_WARM, 63, $urandom);
        send_entry(ntc_r2t_pkg::REQ_WRITE_COLD, COLD_POINTS + 1, $urandom);
        send_entry(ntc_r2t_pkg::REQ_WRITE_COLD, 63, $urandom);
        send_unused_word();
        send_reading(52000);
    endtask

    task automatic test_register_extremes();
        wait_until_drained();
        program_registers(6'd63, 6'd63, 16'h7FFF, 16'h8000);
        send_reading(4000);
        send_reading(900000);
        send_reading(60000);
        send_reading(0);
        send_reading(OHM_MAX);
        wait_until_drained();
        program_registers(6'd0, 6'd0, 16'h8000, 16'h7FFF);
        send_reading(50000);
        send_reading(500000);
        send_reading(0);
        send_reading(OHM_MAX);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_until_drained();
            case (phase)
                0: program_registers(6'd1, 6'd1, 16'h8000, 16'h7FFF);
                1: program_registers(6'd63, 6'd63, ntc_r2t_pkg::TEMP_W'($urandom),
                                     ntc_r2t_pkg::TEMP_W'($urandom));
                default: program_registers(ntc_r2t_pkg::STEP_W'($urandom_range(0, 63)),
                                           ntc_r2t_pkg::STEP_W'($urandom_range(0, 63)),
                                           ntc_r2t_pkg::TEMP_W'($urandom),
                                           ntc_r2t_pkg::TEMP_W'($urandom));
            endcase
            sender_pauses = (phase != RANDOM_PHASES - 1);
            reload_tables(phase == 2);
            repeat (PHASE_MIXED_WORDS) send_mixed_word();
        end
    endtask

    always @(posedge i_clk) begin : check_temps
        ntc_r2t_pkg::t_res want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (temp_readings_due.size() == 0) begin
                report_mismatch("unexpected word, temperature", $signed(o_res.temperature), 0);
            end else begin
                want = temp_readings_due.pop_front();
                if (o_res.temperature !== want.temperature)
                    report_mismatch("temperature", $signed(o_res.temperature),
                                    $signed(want.temperature));
                if (o_res.clamped !== want.clamped)
                    report_mismatch("clamped", o_res.clamped, want.clamped);
                if (o_res.cold_side !== want.cold_side)
                    report_mismatch("cold_side", o_res.cold_side, want.cold_side);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_load();
        test_default_conversions();
        test_segment_corners();
        test_ignored_words();
        test_register_extremes();
        test_random_traffic();
        wait_until_drained();
        if (mismatch_count == 0 && temp_readings_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
